### rtl/core/calendar_hour_adder_defines.svh
// Assertion macros for the calendar hour adder.
// Used by rtl/core/calendar_hour_adder.sv; expects clk_i and rst_ni in scope.
`ifndef CALENDAR_HOUR_ADDER_DEFINES_SVH
`define CALENDAR_HOUR_ADDER_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define CHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define CHA_ASSERT_IMPL(label, ante, cons, msg) \
  `CHA_ASSERT(label, (ante) |-> (cons), msg)

`endif

### rtl/core/cha_pkg.sv
// Shared types, constants and the month length function for the calendar hour adder.
// No dependencies; imported by rtl/core/calendar_hour_adder.sv and sim/tb_top.sv.
package cha_pkg;

  typedef struct packed {
    logic [33:0]        start_stamp;
    logic signed [15:0] hour_offset;
  } cha_in_t;

  typedef struct packed {
    logic [33:0] result_stamp;
    logic        range_error;
  } cha_out_t;

  // divisors pre-shifted to the top quotient bit of each field
  localparam logic [33:0] DIV_C_INIT = 34'd12800000000;  // 1e8 << 7
  localparam logic [33:0] DIV_Y_INIT = 34'd64000000;     // 1e6 << 6
  localparam logic [33:0] DIV_M_INIT = 34'd640000;       // 1e4 << 6
  localparam logic [33:0] DIV_D_INIT = 34'd6400;         // 1e2 << 6

  localparam logic [33:0] MUL_C = 34'd100000000;
  localparam logic [33:0] MUL_Y = 34'd1000000;
  localparam logic [33:0] MUL_M = 34'd10000;
  localparam logic [33:0] MUL_D = 34'd100;

  localparam logic [6:0] YY_MAX      = 7'd99;
  localparam logic [7:0] CENTURY_MAX = 8'd99;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic signed [16:0] HOURS_PER_DAY = 17'sd24;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] days;
    case (m)
      4'd2:                   days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:                days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

### rtl/core/calendar_hour_adder.sv
// Calendar hour adder top level: unpack, validate, day stepping and repack.
// Depends on rtl/core/cha_pkg.sv and rtl/core/calendar_hour_adder_defines.svh.
//
// Takes one word holding a decimal YYYYMMDDHH stamp and a signed hour offset and
// returns one word with the shifted stamp, or the input stamp with range_error set
// when the stamp is invalid or the year leaves 0..9999. One word is in flight at a
// time; in_stall_o is high from acceptance until the result is loaded into the
// output register, which may still be waiting while the next word is accepted.
// Unpacking runs a shared compare-subtract unit, one quotient bit a cycle, and
// ST_CHECK validates the fields. The day loop, one calendar day a cycle, sets the
// worst case; a stamp that is invalid on entry skips it and repacking. Repacking
// runs through ST_PACK_C, ST_PACK_Y and ST_PACK_M, and ST_DONE loads the result.
`include "calendar_hour_adder_defines.svh"

module calendar_hour_adder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cha_pkg::cha_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cha_pkg::cha_out_t out_data_o
);
  import cha_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_DIV_C  = 11'b00000000010,
    ST_DIV_Y  = 11'b00000000100,
    ST_DIV_M  = 11'b00000001000,
    ST_DIV_D  = 11'b00000010000,
    ST_CHECK  = 11'b00000100000,
    ST_STEP   = 11'b00001000000,
    ST_PACK_C = 11'b00010000000,
    ST_PACK_Y = 11'b00100000000,
    ST_PACK_M = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] k_q, k_d;
  logic out_valid_q, out_valid_d;

  logic [33:0] stamp_q, stamp_d;
  logic [33:0] rem_q, rem_d;
  logic [33:0] div_q, div_d;
  logic [7:0]  quo_q, quo_d;
  logic [7:0]  century_q, century_d;
  logic [6:0]  yy_q, yy_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic signed [16:0] total_q, total_d;
  logic        bad_q, bad_d;
  cha_out_t    out_q, out_d;

  logic        ge;
  logic [33:0] diff;
  logic [7:0]  quo_next;
  logic        leap;
  logic [4:0]  mdays_cur;
  logic [4:0]  mdays_prev;
  logic        out_load;

  assign ge         = rem_q >= div_q;
  assign diff       = rem_q - div_q;
  assign quo_next   = {quo_q[6:0], ge};
  assign leap       = (yy_q == 7'd0) ? (century_q[1:0] == 2'd0) : (yy_q[1:0] == 2'd0);
  assign mdays_cur  = month_days(month_q[3:0], leap);
  assign mdays_prev = month_days(4'(month_q[3:0] - 4'd1), leap);

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    stamp_d   = stamp_q;
    rem_d     = rem_q;
    div_d     = div_q;
    quo_d     = quo_q;
    century_d = century_q;
    yy_d      = yy_q;
    month_d   = month_q;
    day_d     = day_q;
    total_d   = total_q;
    bad_d     = bad_q;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          stamp_d = in_data_i.start_stamp;
          rem_d   = in_data_i.start_stamp;
          total_d = {in_data_i.hour_offset[15], in_data_i.hour_offset};
          div_d   = DIV_C_INIT;
          k_d     = 3'd7;
          quo_d   = '0;
          bad_d   = 1'b0;
          state_d = ST_DIV_C;
        end
      end
      ST_DIV_C, ST_DIV_Y, ST_DIV_M, ST_DIV_D: begin
        if (ge) begin
          rem_d = diff;
        end
        quo_d = quo_next;
        div_d = div_q >> 1;
        k_d   = k_q - 3'd1;
        if (k_q == 3'd0) begin
          quo_d = '0;
          k_d   = 3'd6;
          case (state_q)
            ST_DIV_C: begin
              century_d = quo_next;
              div_d     = DIV_Y_INIT;
              state_d   = ST_DIV_Y;
            end
            ST_DIV_Y: begin
              yy_d    = quo_next[6:0];
              div_d   = DIV_M_INIT;
              state_d = ST_DIV_M;
            end
            ST_DIV_M: begin
              month_d = quo_next[6:0];
              div_d   = DIV_D_INIT;
              state_d = ST_DIV_D;
            end
            default: begin
              day_d   = quo_next[6:0];
              state_d = ST_CHECK;
            end
          endcase
        end
      end
      ST_CHECK: begin
        bad_d = (century_q > CENTURY_MAX) || (month_q == 7'd0) || (month_q > MONTH_MAX) ||
                (rem_q[6:0] > HOUR_MAX) || (day_q == 7'd0) || (day_q > {2'b00, mdays_cur});
        total_d = total_q + $signed({10'd0, rem_q[6:0]});
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (bad_q) begin
          state_d = ST_DONE;
        end else if (total_q >= HOURS_PER_DAY) begin
          total_d = total_q - HOURS_PER_DAY;
          if (day_q == {2'b00, mdays_cur}) begin
            day_d = 7'd1;
            if (month_q == MONTH_MAX) begin
              month_d = 7'd1;
              if (yy_q == YY_MAX) begin
                yy_d = 7'd0;
                if (century_q == CENTURY_MAX) begin
                  bad_d = 1'b1;
                end else begin
                  century_d = century_q + 8'd1;
                end
              end else begin
                yy_d = yy_q + 7'd1;
              end
            end else begin
              month_d = month_q + 7'd1;
            end
          end else begin
            day_d = day_q + 7'd1;
          end
        end else if (total_q[16]) begin
          total_d = total_q + HOURS_PER_DAY;
          if (day_q == 7'd1) begin
            if (month_q == 7'd1) begin
              month_d = MONTH_MAX;
              day_d   = 7'd31;
              if (yy_q == 7'd0) begin
                if (century_q == 8'd0) begin
                  bad_d = 1'b1;
                end else begin
                  century_d = century_q - 8'd1;
                  yy_d      = YY_MAX;
                end
              end else begin
                yy_d = yy_q - 7'd1;
              end
            end else begin
              month_d = month_q - 7'd1;
              day_d   = {2'b00, mdays_prev};
            end
          end else begin
            day_d = day_q - 7'd1;
          end
        end else begin
          state_d = ST_PACK_C;
        end
      end
      ST_PACK_C: begin
        rem_d   = 34'(34'(century_q) * MUL_C);
        state_d = ST_PACK_Y;
      end
      ST_PACK_Y: begin
        rem_d   = rem_q + 34'(34'(yy_q) * MUL_Y);
        state_d = ST_PACK_M;
      end
      ST_PACK_M: begin
        rem_d   = rem_q + 34'(34'(month_q) * MUL_M);
        state_d = ST_DONE;
        rem_d   = rem_d + 34'(34'(day_q) * MUL_D) + 34'(total_q[6:0]);
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (out_load) begin
      out_d.result_stamp = bad_q ? stamp_q : rem_q;
      out_d.range_error  = bad_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q   <= stamp_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    quo_q     <= quo_d;
    century_q <= century_d;
    yy_q      <= yy_d;
    month_q   <= month_d;
    day_q     <= day_d;
    total_q   <= total_d;
    bad_q     <= bad_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CHA_ASSERT(a_accept_starts, in_valid_i && !in_stall_o |=> state_q == ST_DIV_C, "accepted word did not start unpacking")
  `CHA_ASSERT_IMPL(a_step_date_ok, state_q == ST_STEP && !bad_q, month_q >= 7'd1 && month_q <= MONTH_MAX && day_q >= 7'd1 && day_q <= 7'd31, "date left calendar range while stepping")
  `CHA_ASSERT_IMPL(a_pack_hour_ok, state_q == ST_PACK_C, !bad_q && total_q >= 17'sd0 && total_q < HOURS_PER_DAY, "hour out of range at repack")
  `CHA_ASSERT(a_load_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result appeared without finishing a word")

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for calendar_hour_adder: directed table plus random stamps and hour offsets.
// Results are checked against a calendar shift model; depends on rtl/core/cha_pkg.sv.
module tb_top;
  import cha_pkg::*;

  localparam int YEAR_TOP     = 9999;
  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_WORDS = 420;
  localparam int TAIL_WORDS   = 60;
  localparam int HOLD_CYCLES  = 6000;
  localparam int DRAIN_CYCLES = 1500;
  localparam int CYCLE_LIMIT  = 3_500_000;

  typedef struct packed {
    logic [33:0] stamp;
    logic [15:0] offset;
    logic        known;
    logic [33:0] res_stamp;
    logic        res_err;
  } dir_row_t;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{34'd2024010100, 16'd0,    1'b1, 34'd2024010100, 1'b0},
    '{34'd9999123123, 16'd0,    1'b1, 34'd9999123123, 1'b0},
    '{34'd10100,      16'd0,    1'b1, 34'd10100,      1'b0},
    '{34'd9999123123, 16'd1,    1'b1, 34'd9999123123, 1'b1},
    '{34'd10100,      16'hFFFF, 1'b1, 34'd10100,      1'b1},
    '{34'h3FFFFFFFF,  16'd5,    1'b1, 34'h3FFFFFFFF,  1'b1},
    '{34'd2023130100, 16'd1,    1'b1, 34'd2023130100, 1'b1},
    '{34'd2023000100, 16'd1,    1'b1, 34'd2023000100, 1'b1},
    '{34'd2023010000, 16'd1,    1'b1, 34'd2023010000, 1'b1},
    '{34'd2023022900, 16'd1,    1'b1, 34'd2023022900, 1'b1},
    '{34'd1900022900, 16'd0,    1'b1, 34'd1900022900, 1'b1},
    '{34'd2023043100, 16'd0,    1'b1, 34'd2023043100, 1'b1},
    '{34'd2023010124, 16'd0,    1'b1, 34'd2023010124, 1'b1},
    '{34'd0,          16'd0,    1'b1, 34'd0,          1'b1},
    '{34'd22900,      16'd0,    1'b1, 34'd22900,      1'b0},
    '{34'd2000022900, 16'd24,   1'b1, 34'd2000030100, 1'b0},
    '{34'd2023123123, 16'd1,    1'b1, 34'd2024010100, 1'b0},
    '{34'd2024010100, 16'hFFFF, 1'b1, 34'd2023123123, 1'b0},
    '{34'd10100,      16'd23,   1'b1, 34'd10123,      1'b0},
    '{34'd9999123100, 16'h7FFF, 1'b1, 34'd9999123100, 1'b1},
    '{34'd10500,      16'h8000, 1'b1, 34'd10500,      1'b1},
    '{34'd2024010100, 16'h7FFF, 1'b0, 34'd0,          1'b0},
    '{34'd2024010100, 16'h8000, 1'b0, 34'd0,          1'b0},
    '{34'd9998010100, 16'h7FFF, 1'b0, 34'd0,          1'b0},
    '{34'd3123123,    16'h8000, 1'b0, 34'd0,          1'b0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  cha_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cha_out_t out_data;

  cha_out_t due_stamps [$];
  cha_out_t head;
  int       fails = 0;
  int       results_checked = 0;
  int       flagged = 0;
  int       words_in = 0;
  int       cycle_count = 0;
  int       hold_at = 1_000_000;
  bit       hold_done = 1'b0;
  bit       tail_phase = 1'b0;

  calendar_hour_adder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  function automatic int month_length(longint y, longint m);
    bit leap;
    int n;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = leap ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic cha_out_t shift_stamp(cha_in_t w);
    cha_out_t r;
    longint   s, yr, mo, dy, hr, tot;
    bit       bad;
    s   = w.start_stamp;
    yr  = s / 1000000;
    mo  = (s / 10000) % 100;
    dy  = (s / 100) % 100;
    hr  = s % 100;
    bad = (yr > YEAR_TOP) || (mo < 1) || (mo > 12) || (hr > 23) || (dy < 1) ||
          (dy > month_length(yr, mo));
    tot = hr + w.hour_offset;
    while (!bad && tot >= 24) begin
      tot -= 24;
      dy++;
      if (dy > month_length(yr, mo)) begin
        dy = 1;
        mo++;
        if (mo > 12) begin
          mo = 1;
          yr++;
          if (yr > YEAR_TOP) bad = 1'b1;
        end
      end
    end
    while (!bad && tot < 0) begin
      tot += 24;
      dy--;
      if (dy < 1) begin
        mo--;
        if (mo < 1) begin
          mo = 12;
          yr--;
          if (yr < 0) bad = 1'b1;
        end
        if (!bad) dy = month_length(yr, mo);
      end
    end
    r.range_error = bad;
    if (bad) begin
      r.result_stamp = w.start_stamp;
    end else begin
      s = yr * 1000000 + mo * 10000 + dy * 100 + tot;
      r.result_stamp = s[33:0];
    end
    return r;
  endfunction

  function automatic cha_in_t draw_word();
    cha_in_t        w;
    longint         s, yr, mo, dy, hr;
    int             kind, off, last;
    bit [63:0]      raw;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       yr = $urandom_range(0, 4);
      1:       yr = $urandom_range(9995, 9999);
      default: yr = $urandom_range(0, 9999);
    endcase
    mo   = $urandom_range(1, 12);
    last = month_length(yr, mo);
    case ($urandom_range(0, 3))
      0:       dy = last;
      1:       dy = 1;
      default: dy = $urandom_range(1, last);
    endcase
    hr = $urandom_range(0, 23);
    if (kind >= 75 && kind < 90) begin
      case ($urandom_range(0, 3))
        0: yr = $urandom_range(10000, 17178);
        1: mo = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
        2: dy = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(last + 1, 99);
        default: hr = $urandom_range(24, 99);
      endcase
    end
    s = yr * 1000000 + mo * 10000 + dy * 100 + hr;
    w.start_stamp = s[33:0];
    if (kind >= 90) begin
      raw = {$urandom, $urandom};
      w.start_stamp = raw[33:0];
    end
    case ($urandom_range(0, 9))
      0, 1, 2: off = $urandom_range(0, 96) - 48;
      3, 4, 5: off = $urandom_range(0, 4000) - 2000;
      default: off = $urandom_range(0, 65535);
    endcase
    w.hour_offset = off[15:0];
    return w;
  endfunction

  initial begin
    cha_in_t  word;
    cha_out_t due;
    hold_at = N_DIRECTED + $urandom_range(20, 200);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < N_DIRECTED + RANDOM_WORDS; i++) begin
      if (i < N_DIRECTED) begin
        word.start_stamp = directed_rows[i].stamp;
        word.hour_offset = directed_rows[i].offset;
      end else begin
        word = draw_word();
      end
      due = shift_stamp(word);
      if (i < N_DIRECTED && directed_rows[i].known) begin
        due.result_stamp = directed_rows[i].res_stamp;
        due.range_error  = directed_rows[i].res_err;
      end
      tail_phase = (i >= N_DIRECTED + RANDOM_WORDS - TAIL_WORDS);
      @(negedge clk);
      in_valid <= 1'b1;
      in_data  <= word;
      do @(posedge clk); while (in_stall);
      due_stamps.insert(due_stamps.size(), due);
      words_in++;
      if (!tail_phase && $urandom_range(0, 2) == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_stamps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d words: %0d table rows, %0d random, one output hold of %0d cycles",
             words_in, N_DIRECTED, RANDOM_WORDS, HOLD_CYCLES);
    $display("Checked %0d results, %0d with range_error set, %0d mismatches",
             results_checked, flagged, fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // output side: long hold once, random stall bursts, none in the tail
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && words_in >= hold_at) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_stamps.size() == 0) begin
        $display("%0t: unexpected word, expected none, got stamp %0d flag %0d",
                 $time, out_data.result_stamp, out_data.range_error);
        fails++;
      end else begin
        head = due_stamps.pop_front();
        results_checked++;
        if (head.range_error) flagged++;
        if (out_data.result_stamp !== head.result_stamp) begin
          $display("%0t: result_stamp expected %0d got %0d",
                   $time, head.result_stamp, out_data.result_stamp);
          fails++;
        end
        if (out_data.range_error !== head.range_error) begin
          $display("%0t: range_error expected %0d got %0d",
                   $time, head.range_error, out_data.range_error);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending",
               $time, cycle_count, due_stamps.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cha_pkg.sv
rtl/core/calendar_hour_adder.sv
sim/tb_top.sv
